// File: hdl/owm_pkg.sv
// ---------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Item and result records, phase codes and standard-speed slot timings.
// ---------------------------------------------------------------------------
package owm_pkg;

	// Input mode codes (tick or command)
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_RESET = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// Bus sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_RST_LOW   = 3'd1,
		PH_RST_REL   = 3'd2,
		PH_RST_WAIT  = 3'd3,
		PH_SLOT_LOW  = 3'd4,
		PH_SLOT_HIGH = 3'd5,
		PH_READ_POST = 3'd6
	} phase_t;

	// Microsecond counts (9-bit tick counter)
	localparam logic [8:0] T_RST_LOW   = 9'd480;
	localparam logic [8:0] T_RST_REL   = 9'd70;
	localparam logic [8:0] T_RST_WAIT  = 9'd410;
	localparam logic [8:0] T_SHORT_LOW = 9'd6;
	localparam logic [8:0] T_READ_SMP  = 9'd9;
	localparam logic [8:0] T_READ_POST = 9'd55;
	localparam logic [8:0] T_ZERO_LOW  = 9'd60;
	localparam logic [8:0] T_ZERO_HIGH = 9'd10;
	localparam logic [8:0] T_ONE_HIGH  = 9'd64;

	// Classified item passed from front end to engine
	typedef struct packed {
		logic       is_cmd;
		mode_t      mode;
		logic [7:0] tx_byte;
		logic       line_level;
	} item_t;

	// One result record
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       device_present;
		logic       done_res;
		logic       busy_res;
		logic       line_low;
	} result_t;

endpackage

// File: hdl/one_wire_bus_master.sv
// ---------------------------------------------------------------------------
// one_wire_bus_master: standard-speed 1-Wire bus master
// Command and microsecond-tick items in, one bus status result per item out.
//
//   Channel   Dir  tdata                                   tuser
//   s_*       in   [7:0] tx_byte, [8] line_level           [1:0] mode
//   m_*       out  [0] line_low, [1] busy_res, [2] done_res, -
//                  [3] device_present, [11:4] rx_byte
//
// One item per clock sustained while m_tready is high; each item passes the
// input register, the queue and the result register, and the engine updates
// phase and counter in one step per item. Reset (arst_n low) idles the bus
// and empties the queue. A stalled m_tready backs up through the queue to
// s_tready only once the queue is full.
// ---------------------------------------------------------------------------
module one_wire_bus_master #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] line_level, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] line_low, [1] busy_res, [2] done_res,
	                               // [3] device_present, [11:4] rx_byte, rest zero
);

	logic             push_valid;
	logic             push_ready;
	owm_pkg::item_t   push_item;
	logic             pop_valid;
	logic             pop_ready;
	owm_pkg::item_t   pop_item;
	owm_pkg::result_t res;

	// Front end: accept and classify
	owm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_mode      (owm_pkg::mode_t'(s_tuser)),
		.in_tx_byte   (s_tdata[7:0]),
		.in_line_level(s_tdata[8]),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	// Queue between front end and engine
	owm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_item  (pop_item)
	);

	// Back end: bus timing
	owm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {4'd0, res};

endmodule

// File: hdl/owm_front.sv
// ---------------------------------------------------------------------------
// owm_front: input stage
// Takes input transfers, classifies them as command or tick and registers
// them for the item queue.
// ---------------------------------------------------------------------------
module owm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  owm_pkg::mode_t    in_mode,
	input  logic [7:0]        in_tx_byte,
	input  logic              in_line_level,
	output logic              push_valid,
	input  logic              push_ready,
	output owm_pkg::item_t    push_item
);

	logic           valid_s1;
	owm_pkg::item_t item_s1;

	// Stage is free when empty or draining this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload with classification
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.is_cmd     <= (in_mode != owm_pkg::MODE_TICK);
			item_s1.mode       <= in_mode;
			item_s1.tx_byte    <= in_tx_byte;
			item_s1.line_level <= in_line_level;
		end
	end

endmodule

// File: hdl/owm_queue.sv
// ---------------------------------------------------------------------------
// owm_queue: item queue
// Small register FIFO between the front end and the bus engine.
// ---------------------------------------------------------------------------
module owm_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  owm_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output owm_pkg::item_t rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	owm_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// File: hdl/owm_engine.sv
// ---------------------------------------------------------------------------
// owm_engine: bus timing engine
// Runs reset, write-byte and read-byte sequences one tick per item and
// registers one result per item.
// ---------------------------------------------------------------------------
module owm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  owm_pkg::item_t    item,
	output logic              res_valid,
	input  logic              res_ready,
	output owm_pkg::result_t  res
);

	owm_pkg::phase_t  phase_q, phase_d;
	owm_pkg::mode_t   op_q, op_d;
	logic [8:0]       tick_q, tick_d;
	logic [2:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic             present_q, present_d;
	logic             drive_q, drive_d;
	logic             done;
	logic [8:0]       tick_inc;
	logic             wbit;
	logic             is_read;
	logic [8:0]       lim_low;
	logic [8:0]       lim_high;
	logic             step;
	logic             res_valid_q;
	owm_pkg::result_t res_q;
	owm_pkg::result_t res_d;

	// Take an item when the result register is free or draining
	assign item_ready = !res_valid_q || res_ready;
	assign step       = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// Slot timing selection
	assign tick_inc = tick_q + 9'd1;
	assign wbit     = shift_q[bit_q];
	assign is_read  = (op_q == owm_pkg::MODE_READ);
	assign lim_low  = (is_read || wbit) ? owm_pkg::T_SHORT_LOW : owm_pkg::T_ZERO_LOW;
	assign lim_high = is_read ? owm_pkg::T_READ_SMP
	                : (wbit ? owm_pkg::T_ONE_HIGH : owm_pkg::T_ZERO_HIGH);

	// Next state and result
	always_comb begin
		phase_d   = phase_q;
		op_d      = op_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		present_d = present_q;
		drive_d   = drive_q;
		done      = 1'b0;

		if (item.is_cmd) begin
			// new command only when idle
			if (phase_q == owm_pkg::PH_IDLE) begin
				op_d      = item.mode;
				tick_d    = '0;
				bit_d     = '0;
				present_d = 1'b0;
				shift_d   = (item.mode == owm_pkg::MODE_WRITE) ? item.tx_byte : 8'd0;
				phase_d   = (item.mode == owm_pkg::MODE_RESET) ? owm_pkg::PH_RST_LOW
				                                               : owm_pkg::PH_SLOT_LOW;
				drive_d   = 1'b1;
			end
		end else if (phase_q != owm_pkg::PH_IDLE) begin
			tick_d = tick_inc;
			case (phase_q)
				owm_pkg::PH_RST_LOW: begin
					if (tick_inc >= owm_pkg::T_RST_LOW) begin
						phase_d = owm_pkg::PH_RST_REL;
						drive_d = 1'b0;
						tick_d  = '0;
					end
				end
				owm_pkg::PH_RST_REL: begin
					if (tick_inc >= owm_pkg::T_RST_REL) begin
						tick_d = '0;
						if (item.line_level) begin
							// no presence pulse: finish now
							present_d = 1'b0;
							phase_d   = owm_pkg::PH_IDLE;
							drive_d   = 1'b0;
							done      = 1'b1;
						end else begin
							present_d = 1'b1;
							phase_d   = owm_pkg::PH_RST_WAIT;
						end
					end
				end
				owm_pkg::PH_RST_WAIT: begin
					if (tick_inc >= owm_pkg::T_RST_WAIT) begin
						phase_d = owm_pkg::PH_IDLE;
						drive_d = 1'b0;
						tick_d  = '0;
						done    = 1'b1;
					end
				end
				owm_pkg::PH_SLOT_LOW: begin
					if (tick_inc >= lim_low) begin
						phase_d = owm_pkg::PH_SLOT_HIGH;
						drive_d = 1'b0;
						tick_d  = '0;
					end
				end
				owm_pkg::PH_SLOT_HIGH, owm_pkg::PH_READ_POST: begin
					if (phase_q == owm_pkg::PH_SLOT_HIGH && is_read) begin
						// read sample point
						if (tick_inc >= lim_high) begin
							shift_d = {item.line_level, shift_q[7:1]};
							phase_d = owm_pkg::PH_READ_POST;
							tick_d  = '0;
						end
					end else if ((phase_q == owm_pkg::PH_SLOT_HIGH && tick_inc >= lim_high)
					          || (phase_q == owm_pkg::PH_READ_POST
					              && tick_inc >= owm_pkg::T_READ_POST)) begin
						// end of bit slot
						tick_d = '0;
						if (bit_q == 3'd7) begin
							phase_d = owm_pkg::PH_IDLE;
							drive_d = 1'b0;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = owm_pkg::PH_SLOT_LOW;
							drive_d = 1'b1;
						end
					end
				end
				default: begin
					// unused code: drop back to idle silently
					phase_d = owm_pkg::PH_IDLE;
					drive_d = 1'b0;
					tick_d  = '0;
				end
			endcase
		end

		res_d.line_low       = drive_d;
		res_d.busy_res       = (phase_d != owm_pkg::PH_IDLE);
		res_d.done_res       = done;
		res_d.device_present = done && (op_d == owm_pkg::MODE_RESET) && present_d;
		res_d.rx_byte        = (done && op_d == owm_pkg::MODE_READ) ? shift_d : 8'd0;
	end

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= owm_pkg::PH_IDLE;
			op_q      <= owm_pkg::MODE_TICK;
			tick_q    <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			present_q <= 1'b0;
			drive_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			op_q      <= op_d;
			tick_q    <= tick_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			present_q <= present_d;
			drive_q   <= drive_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_ready) begin
			res_valid_q <= item_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

endmodule

// File: tb/one_wire_bus_master_test.sv
// ---------------------------------------------------------------------------
// one_wire_bus_master_test: self-checking bench for the 1-Wire bus master
// Drives command and tick items on the input stream, predicts the bus status
// of every item with a cycle-free model of the slot sequencer, and checks
// each transfer on the output stream field by field. The run issues read
// byte, bus reset and write byte operations in turn, with stray commands and
// idle ticks between them, under three sender/receiver idle profiles.
// ---------------------------------------------------------------------------
module one_wire_bus_master_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT   = 2000;	// cycles without any transfer
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEMS_TARGET  = 1050;
	localparam int STRAY_PCT     = 2;

	// How the sampled bus level is chosen for each tick
	typedef enum int {
		LINE_ALL_HIGH,
		LINE_RANDOM
	} line_pick_t;

	// Bus status predictor and store of expected status words
	class owm_status_scoreboard;
		owm_pkg::phase_t  phase;
		owm_pkg::mode_t   op;
		logic [8:0]       ticks;
		logic [2:0]       bit_idx;
		logic [7:0]       shreg;
		logic             present;
		logic             drive;
		owm_pkg::result_t expected_status[$];
		int               errors;
		int               items_seen;
		int               resets_done;
		int               presence_seen;
		int               writes_done;
		int               reads_done;
		int               ignored_cmds;

		function new();
			phase = owm_pkg::PH_IDLE;
			op = owm_pkg::MODE_TICK;
			ticks = '0;
			bit_idx = '0;
			shreg = '0;
			present = 1'b0;
			drive = 1'b0;
			errors = 0;
			items_seen = 0;
			resets_done = 0;
			presence_seen = 0;
			writes_done = 0;
			reads_done = 0;
			ignored_cmds = 0;
		endfunction

		function bit is_busy();
			return phase != owm_pkg::PH_IDLE;
		endfunction

		// Advance the sequencer by one accepted item and queue its status
		function void accept_item(owm_pkg::mode_t m, logic [7:0] tx, logic lvl);
			owm_pkg::result_t r;
			logic             done;
			logic             slot_end;
			logic             wbit;
			logic [8:0]       lim;
			done = 1'b0;
			slot_end = 1'b0;
			items_seen++;
			if (m != owm_pkg::MODE_TICK) begin
				if (phase == owm_pkg::PH_IDLE) begin
					op = m;
					ticks = '0;
					bit_idx = '0;
					present = 1'b0;
					shreg = (m == owm_pkg::MODE_WRITE) ? tx : 8'd0;
					phase = (m == owm_pkg::MODE_RESET) ? owm_pkg::PH_RST_LOW
					                                   : owm_pkg::PH_SLOT_LOW;
					drive = 1'b1;
				end else begin
					ignored_cmds++;
				end
			end else if (phase != owm_pkg::PH_IDLE) begin
				ticks = ticks + 9'd1;
				wbit = shreg[bit_idx];
				case (phase)
				owm_pkg::PH_RST_LOW: if (ticks >= owm_pkg::T_RST_LOW) begin
					phase = owm_pkg::PH_RST_REL;
					drive = 1'b0;
					ticks = '0;
				end
				owm_pkg::PH_RST_REL: if (ticks >= owm_pkg::T_RST_REL) begin
					// presence pulse: device holds the line low at the sample
					if (lvl) begin
						present = 1'b0;
						done = 1'b1;
					end else begin
						present = 1'b1;
						phase = owm_pkg::PH_RST_WAIT;
						ticks = '0;
					end
				end
				owm_pkg::PH_RST_WAIT: if (ticks >= owm_pkg::T_RST_WAIT)
					done = 1'b1;
				owm_pkg::PH_SLOT_LOW: begin
					lim = (op == owm_pkg::MODE_READ || wbit) ? owm_pkg::T_SHORT_LOW
					                                         : owm_pkg::T_ZERO_LOW;
					if (ticks >= lim) begin
						phase = owm_pkg::PH_SLOT_HIGH;
						drive = 1'b0;
						ticks = '0;
					end
				end
				owm_pkg::PH_SLOT_HIGH: begin
					if (op == owm_pkg::MODE_READ)
						lim = owm_pkg::T_READ_SMP;
					else
						lim = wbit ? owm_pkg::T_ONE_HIGH : owm_pkg::T_ZERO_HIGH;
					if (ticks >= lim) begin
						if (op == owm_pkg::MODE_READ) begin
							shreg = {lvl, shreg[7:1]};
							phase = owm_pkg::PH_READ_POST;
							ticks = '0;
						end else begin
							slot_end = 1'b1;
						end
					end
				end
				owm_pkg::PH_READ_POST: if (ticks >= owm_pkg::T_READ_POST)
					slot_end = 1'b1;
				default: begin
					// unused phase code drops back to idle, no done
					phase = owm_pkg::PH_IDLE;
					drive = 1'b0;
					ticks = '0;
				end
				endcase
				// next bit's low pulse follows right after the slot
				if (slot_end) begin
					if (bit_idx == 3'd7) begin
						done = 1'b1;
					end else begin
						bit_idx = bit_idx + 3'd1;
						phase = owm_pkg::PH_SLOT_LOW;
						drive = 1'b1;
						ticks = '0;
					end
				end
				if (done) begin
					phase = owm_pkg::PH_IDLE;
					drive = 1'b0;
					ticks = '0;
					case (op)
					owm_pkg::MODE_RESET: begin
						resets_done++;
						if (present)
							presence_seen++;
					end
					owm_pkg::MODE_WRITE: writes_done++;
					owm_pkg::MODE_READ: reads_done++;
					default: ;
					endcase
				end
			end
			r.line_low = drive;
			r.busy_res = (phase != owm_pkg::PH_IDLE);
			r.done_res = done;
			r.device_present = (done && op == owm_pkg::MODE_RESET) ? present : 1'b0;
			r.rx_byte = (done && op == owm_pkg::MODE_READ) ? shreg : 8'd0;
			expected_status.push_back(r);
		endfunction

		// Compare one output transfer with the oldest expected status
		function void check_status(logic [15:0] word);
			owm_pkg::result_t exp_r;
			owm_pkg::result_t got;
			if (expected_status.size() == 0) begin
				$error("unexpected output transfer, data %h", word);
				errors++;
				return;
			end
			exp_r = expected_status.pop_front();
			got = owm_pkg::result_t'(word[11:0]);
			if (got.line_low !== exp_r.line_low) begin
				$error("line_low: expected %0d, got %0d", exp_r.line_low, got.line_low);
				errors++;
			end
			if (got.busy_res !== exp_r.busy_res) begin
				$error("busy_res: expected %0d, got %0d", exp_r.busy_res, got.busy_res);
				errors++;
			end
			if (got.done_res !== exp_r.done_res) begin
				$error("done_res: expected %0d, got %0d", exp_r.done_res, got.done_res);
				errors++;
			end
			if (got.device_present !== exp_r.device_present) begin
				$error("device_present: expected %0d, got %0d",
					exp_r.device_present, got.device_present);
				errors++;
			end
			if (got.rx_byte !== exp_r.rx_byte) begin
				$error("rx_byte: expected %h, got %h", exp_r.rx_byte, got.rx_byte);
				errors++;
			end
			if (word[15:12] !== 4'd0) begin
				$error("m_tdata pad: expected 0, got %h", word[15:12]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;	// [7:0] tx_byte, [8] line_level, rest zero
	logic [1:0]  s_tuser;	// [1:0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;	// [0] line_low, [1] busy_res, [2] done_res,
				// [3] device_present, [11:4] rx_byte

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;
	owm_status_scoreboard sb = new();

	one_wire_bus_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Output side: check each transfer, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("one_wire_bus_master_test NOT OK");
				$finish;
			end
		end
	end

	function automatic logic pick_level(line_pick_t p);
		case (p)
		LINE_ALL_HIGH: return 1'b1;
		default: return 1'($urandom);
		endcase
	endfunction

	// Present one item, with random idle cycles ahead of it
	task automatic send_item(owm_pkg::mode_t m, logic [7:0] tx, logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, lvl, tx};
		s_tuser <= m;
		do
			@(posedge clk);
		while (!s_tready);
		sb.accept_item(m, tx, lvl);
	endtask

	// Hold the sender off until every expected status has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int             op_idx;
		int             phase_end;
		owm_pkg::mode_t op_m;
		line_pick_t     pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = owm_pkg::MODE_TICK;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations in turn (read, then reset, then write), with idle ticks
		// ahead of each command and stray commands while busy. The profile
		// switches on item count, so an operation may span a switch.
		op_idx = 0;
		pick = LINE_RANDOM;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				send_idle_pct = 29;
				recv_idle_pct = 62;
			end
			1: begin
				send_idle_pct = 62;
				recv_idle_pct = 29;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			phase_end = (ITEMS_TARGET * (ph + 1)) / 3;
			while (sb.items_seen < phase_end || (ph == 2 && sb.is_busy())) begin
				if (sb.is_busy()) begin
					if ($urandom_range(99) < STRAY_PCT)
						send_item(owm_pkg::mode_t'($urandom_range(3, 1)), 8'($urandom),
							pick_level(pick));
					else
						send_item(owm_pkg::MODE_TICK, 8'($urandom), pick_level(pick));
				end else begin
					// ticks while idle are ignored
					repeat ($urandom_range(3, 1))
						send_item(owm_pkg::MODE_TICK, 8'($urandom), 1'($urandom));
					// reset sees a high line at the sample: no presence, short run
					case (op_idx % 3)
					0: begin
						op_m = owm_pkg::MODE_READ;
						pick = LINE_RANDOM;
					end
					1: begin
						op_m = owm_pkg::MODE_RESET;
						pick = LINE_ALL_HIGH;
					end
					default: begin
						op_m = owm_pkg::MODE_WRITE;
						pick = LINE_RANDOM;
					end
					endcase
					send_item(op_m, 8'($urandom), pick_level(pick));
					op_idx++;
				end
			end
			drain();
		end

		// Let the pipeline settle before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d resets (%0d with presence), %0d writes, %0d reads",
			sb.items_seen, sb.resets_done, sb.presence_seen, sb.writes_done,
			sb.reads_done);
		$display("%0d commands ignored while busy, three sender/receiver idle profiles",
			sb.ignored_cmds);
		if (sb.errors == 0 && sb.expected_status.size() == 0)
			$display("one_wire_bus_master_test OK");
		else
			$display("one_wire_bus_master_test NOT OK");
		$finish;
	end

endmodule

// File: files.f
hdl/owm_pkg.sv
hdl/owm_front.sv
hdl/owm_queue.sv
hdl/owm_engine.sv
hdl/one_wire_bus_master.sv
tb/one_wire_bus_master_test.sv
